/* hw/rtl/ddr_pkg.sv */
// Shared types, codes and constants of the dawn/dusk RGB ramp.
package ddr_pkg;

    localparam int TIME_W = 17;
    localparam int RISE_W = 15;
    localparam int RATE_W = 32;
    localparam int LEVEL_W = 16;
    localparam int TEN_W = 23;   // signed time in tenths of a second
    localparam int ELAP_W = 19;  // elapsed tenths, at most ten ramp lengths
    localparam int Q_W = 35;     // elapsed * rate / 65536
    localparam int CFG_IDX_W = 3;

    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_DAWN = 2'd1;
    localparam logic [1:0] MODE_DUSK = 2'd2;

    localparam logic [1:0] OP_ZERO = 2'd0;
    localparam logic [1:0] OP_RISE = 2'd1;
    localparam logic [1:0] OP_FALL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SUNRISE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SUNSET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RISE_LEN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RED_RATE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_RATE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_RATE = 3'd5;

    localparam logic [TIME_W-1:0] RST_SUNRISE = 17'd21600;
    localparam logic [TIME_W-1:0] RST_SUNSET = 17'd64800;
    localparam logic [RISE_W-1:0] RST_RISE_LEN = 15'd5400;
    localparam logic [RATE_W-1:0] RST_RED_RATE = 32'd795352;
    localparam logic [RATE_W-1:0] RST_GREEN_RATE = 32'd994190;
    localparam logic [RATE_W-1:0] RST_BLUE_RATE = 32'd1325587;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 16'hFFFF;
    // q >= 10 * 65535 means the level is at or past full scale
    localparam logic [Q_W-1:0] Q_SAT = 35'd655350;
    // q / 10 = (q * ceil(2^23 / 10)) >> 23, exact for q below 2^22
    localparam logic [19:0] DIV10_MUL = 20'd838861;

    typedef struct packed {
        logic [TIME_W-1:0] sunrise;
        logic [TIME_W-1:0] sunset;
        logic [RISE_W-1:0] rise_len;
        logic [RATE_W-1:0] red_rate;
        logic [RATE_W-1:0] green_rate;
        logic [RATE_W-1:0] blue_rate;
    } t_cfg;

    typedef struct packed {
        logic [1:0]        op;
        logic [ELAP_W-1:0] elapsed;
    } t_chan;

    typedef struct packed {
        logic [1:0] mode;
        logic       lights_on;
        t_chan      red;
        t_chan      green;
        t_chan      blue;
    } t_win;

    typedef struct packed {
        logic s3;
        logic s4;
    } t_pipe_en;

endpackage

/* hw/rtl/ddr_window.sv */
// Window decode: ramp mode, lights-on flag and per-channel elapsed time.
module ddr_window (
    input  logic [ddr_pkg::TIME_W-1:0] i_time,
    input  ddr_pkg::t_cfg              i_cfg,
    output ddr_pkg::t_win              o_win
);

    logic signed [ddr_pkg::TEN_W-1:0] w_t10;
    logic signed [ddr_pkg::TEN_W-1:0] w_r5;
    logic signed [ddr_pkg::TEN_W-1:0] w_r2;
    logic signed [ddr_pkg::TEN_W-1:0] w_r4;
    logic signed [ddr_pkg::TEN_W-1:0] w_rise10;
    logic signed [ddr_pkg::TEN_W-1:0] w_set10;
    logic signed [ddr_pkg::TEN_W-1:0] w_dawn10;
    logic signed [ddr_pkg::TEN_W-1:0] w_on10;
    logic signed [ddr_pkg::TEN_W-1:0] w_off10;
    logic signed [ddr_pkg::TEN_W-1:0] w_dusk10;
    logic signed [ddr_pkg::TEN_W-1:0] w_e_dawn;
    logic signed [ddr_pkg::TEN_W-1:0] w_e_green;
    logic signed [ddr_pkg::TEN_W-1:0] w_e_blue;
    logic signed [ddr_pkg::TEN_W-1:0] w_e_dusk;
    logic                             w_in_dawn;
    logic                             w_in_dusk;

    assign w_t10 = $signed(ddr_pkg::TEN_W'(i_time) * ddr_pkg::TEN_W'(10));
    assign w_rise10 = $signed(ddr_pkg::TEN_W'(i_cfg.sunrise) * ddr_pkg::TEN_W'(10));
    assign w_set10 = $signed(ddr_pkg::TEN_W'(i_cfg.sunset) * ddr_pkg::TEN_W'(10));
    assign w_r5 = $signed(ddr_pkg::TEN_W'(i_cfg.rise_len) * ddr_pkg::TEN_W'(5));
    assign w_r2 = $signed(ddr_pkg::TEN_W'(i_cfg.rise_len) * ddr_pkg::TEN_W'(2));
    assign w_r4 = $signed(ddr_pkg::TEN_W'(i_cfg.rise_len) * ddr_pkg::TEN_W'(4));

    assign w_dawn10 = w_rise10 - w_r5;
    assign w_on10 = w_rise10 + w_r5;
    assign w_off10 = w_set10 - w_r5;
    assign w_dusk10 = w_set10 + w_r5;

    assign w_in_dawn = (w_t10 >= w_dawn10) && (w_t10 <= w_on10);
    assign w_in_dusk = (w_t10 <= w_dusk10) && (w_t10 >= w_off10);

    assign w_e_dawn = w_t10 - w_dawn10;
    assign w_e_green = w_e_dawn - w_r2;
    assign w_e_blue = w_e_dawn - w_r4;
    assign w_e_dusk = w_t10 - w_off10;

    always_comb begin
        o_win = '0;
        o_win.lights_on = (w_t10 > w_on10) && (w_t10 < w_off10);
        if (w_in_dawn) begin
            // green and blue start late; hold them at zero until then
            o_win.mode = ddr_pkg::MODE_DAWN;
            o_win.red.op = ddr_pkg::OP_RISE;
            o_win.red.elapsed = w_e_dawn[ddr_pkg::ELAP_W-1:0];
            o_win.green.op = w_e_green[ddr_pkg::TEN_W-1] ? ddr_pkg::OP_ZERO
                                                         : ddr_pkg::OP_RISE;
            o_win.green.elapsed = w_e_green[ddr_pkg::ELAP_W-1:0];
            o_win.blue.op = w_e_blue[ddr_pkg::TEN_W-1] ? ddr_pkg::OP_ZERO
                                                       : ddr_pkg::OP_RISE;
            o_win.blue.elapsed = w_e_blue[ddr_pkg::ELAP_W-1:0];
        end else if (w_in_dusk) begin
            o_win.mode = ddr_pkg::MODE_DUSK;
            o_win.red.op = ddr_pkg::OP_FALL;
            o_win.red.elapsed = w_e_dusk[ddr_pkg::ELAP_W-1:0];
            o_win.green.op = ddr_pkg::OP_FALL;
            o_win.green.elapsed = w_e_dusk[ddr_pkg::ELAP_W-1:0];
            o_win.blue.op = ddr_pkg::OP_FALL;
            o_win.blue.elapsed = w_e_dusk[ddr_pkg::ELAP_W-1:0];
        end
    end

endmodule

/* hw/rtl/ddr_scale.sv */
// One colour channel: elapsed time times rate, divide by ten, clamp; a falling ramp counts down from full.
module ddr_scale (
    input  logic                        i_clk,
    input  ddr_pkg::t_pipe_en           i_en,
    input  ddr_pkg::t_chan              i_chan,
    input  logic [ddr_pkg::RATE_W-1:0]  i_rate,
    output logic [ddr_pkg::LEVEL_W-1:0] o_level
);

    logic [ddr_pkg::ELAP_W+ddr_pkg::RATE_W-1:0] w_prod;
    logic [ddr_pkg::Q_W-1:0]                    r_q;
    logic [1:0]                                 r_op;
    logic [39:0]                                w_div;
    logic [ddr_pkg::LEVEL_W-1:0]                w_p;
    logic                                       w_sat;
    logic [ddr_pkg::LEVEL_W-1:0]                n_level;
    logic [ddr_pkg::LEVEL_W-1:0]                r_level;

    assign w_prod = (ddr_pkg::ELAP_W + ddr_pkg::RATE_W)'(i_chan.elapsed)
                  * (ddr_pkg::ELAP_W + ddr_pkg::RATE_W)'(i_rate);

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_q <= w_prod[ddr_pkg::ELAP_W+ddr_pkg::RATE_W-1:16];
            r_op <= i_chan.op;
        end
    end

    assign w_sat = (r_q >= ddr_pkg::Q_SAT);
    assign w_div = 40'(r_q[19:0]) * 40'(ddr_pkg::DIV10_MUL);
    assign w_p = w_div[38:23];

    always_comb begin
        case (r_op)
            ddr_pkg::OP_RISE: n_level = w_sat ? ddr_pkg::LEVEL_MAX : w_p;
            ddr_pkg::OP_FALL: n_level = w_sat ? '0 : ddr_pkg::LEVEL_MAX - w_p;
            default:          n_level = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_level <= n_level;
        end
    end

    assign o_level = r_level;

endmodule

/* hw/rtl/dawn_dusk_rgb_ramp.sv */
// Result path: an accepted item passes the time, window, product and level registers in order before it is valid.
// Throughput: one item per cycle while the output is not stalled; each of the four stages holds one item.
// Pacing: stage 3 (elapsed times rate) and stage 4 (divide by ten and clamp) set the path.
// Reset: synchronous active-low; clears stage valid bits and loads register defaults.
// Stalls: a stage holds when its successor is full and cannot move on.
module dawn_dusk_rgb_ramp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [ddr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]                   i_cfg_data,
    // input items
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [23:0]                   i_s_tdata,  // [16:0] time_of_day_sec
    // result items
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [1:0] ramp_mode, [2] lights_on, [18:3] red_level, [34:19] green_level,
    // [50:35] blue_level
    output logic [55:0]                   o_m_tdata
);

    ddr_pkg::t_cfg               r_cfg;
    logic [ddr_pkg::TIME_W-1:0]  r_time;
    ddr_pkg::t_win               w_win;
    ddr_pkg::t_win               r_win;
    logic [1:0]                  r_mode3;
    logic                        r_on3;
    logic [1:0]                  r_mode4;
    logic                        r_on4;
    logic                        r_v1;
    logic                        r_v2;
    logic                        r_v3;
    logic                        r_v4;
    logic                        w_rdy1;
    logic                        w_rdy2;
    logic                        w_rdy3;
    logic                        w_rdy4;
    ddr_pkg::t_pipe_en           w_en;
    logic [ddr_pkg::LEVEL_W-1:0] w_red;
    logic [ddr_pkg::LEVEL_W-1:0] w_green;
    logic [ddr_pkg::LEVEL_W-1:0] w_blue;

    // Configuration registers; indexes past the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sunrise <= ddr_pkg::RST_SUNRISE;
            r_cfg.sunset <= ddr_pkg::RST_SUNSET;
            r_cfg.rise_len <= ddr_pkg::RST_RISE_LEN;
            r_cfg.red_rate <= ddr_pkg::RST_RED_RATE;
            r_cfg.green_rate <= ddr_pkg::RST_GREEN_RATE;
            r_cfg.blue_rate <= ddr_pkg::RST_BLUE_RATE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ddr_pkg::REG_SUNRISE:    r_cfg.sunrise <= i_cfg_data[ddr_pkg::TIME_W-1:0];
                ddr_pkg::REG_SUNSET:     r_cfg.sunset <= i_cfg_data[ddr_pkg::TIME_W-1:0];
                ddr_pkg::REG_RISE_LEN:   r_cfg.rise_len <= i_cfg_data[ddr_pkg::RISE_W-1:0];
                ddr_pkg::REG_RED_RATE:   r_cfg.red_rate <= i_cfg_data;
                ddr_pkg::REG_GREEN_RATE: r_cfg.green_rate <= i_cfg_data;
                ddr_pkg::REG_BLUE_RATE:  r_cfg.blue_rate <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A stage may load when it is empty or its contents move on this cycle.
    assign w_rdy4 = !r_v4 || i_m_tready;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign o_s_tready = w_rdy1;
    assign w_en.s3 = w_rdy3;
    assign w_en.s4 = w_rdy4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_s_tvalid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // Stage 1: capture the time sample.
    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_time <= i_s_tdata[ddr_pkg::TIME_W-1:0];
        end
    end

    ddr_window u_window (
        .i_time (r_time),
        .i_cfg  (r_cfg),
        .o_win  (w_win)
    );

    // Stage 2: hold the decoded window; carry mode and lights-on down the pipe.
    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            r_win <= w_win;
        end
        if (w_rdy3) begin
            r_mode3 <= r_win.mode;
            r_on3 <= r_win.lights_on;
        end
        if (w_rdy4) begin
            r_mode4 <= r_mode3;
            r_on4 <= r_on3;
        end
    end

    // Stages 3 and 4 live inside each channel.
    ddr_scale u_red (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_chan  (r_win.red),
        .i_rate  (r_cfg.red_rate),
        .o_level (w_red)
    );

    ddr_scale u_green (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_chan  (r_win.green),
        .i_rate  (r_cfg.green_rate),
        .o_level (w_green)
    );

    ddr_scale u_blue (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_chan  (r_win.blue),
        .i_rate  (r_cfg.blue_rate),
        .o_level (w_blue)
    );

    assign o_m_tvalid = r_v4;
    assign o_m_tdata = {5'd0, w_blue, w_green, w_red, r_on4, r_mode4};

`ifndef NO_ASSERTIONS
    // Outside both ramps every level is dark.
    a_none_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (r_mode4 == ddr_pkg::MODE_NONE))
            |-> (w_red == '0 && w_green == '0 && w_blue == '0))
        else $error("levels nonzero outside ramps");

    // Lights-on lies strictly between the two windows.
    a_on_no_ramp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_on4) |-> (r_mode4 == ddr_pkg::MODE_NONE))
        else $error("lights on during a ramp");

    // A full stage 3 whose successor is blocked keeps its item.
    a_s3_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !w_rdy4) |=> r_v3)
        else $error("stage 3 item lost under stall");
`endif

endmodule
